// ===== src/icrt_pkg.sv =====
// shared types, codes and constants for the i/o card read transaction block
// no dependencies; the csr, datapath, controller and top files refer to it by scoped names
package icrt_pkg;

   // reply buffer and card geometry
   localparam int REPLY_DEPTH      = 64;
   localparam int ANALOG_CHANNELS  = 16;
   localparam int COUNTER_CHANNELS = 12;
   localparam int DIGITAL_BITS     = 16;

   localparam int CNT_W  = $clog2(REPLY_DEPTH + 1);
   localparam int ADDR_W = $clog2(REPLY_DEPTH);
   localparam int STEP_W = $clog2(DIGITAL_BITS);

   // reply layout: data byte pairs start after the header
   localparam int DATA_FIRST     = 7;
   localparam int SUM_FIRST      = 2;
   localparam int REQ_LAST       = 8;
   localparam int ANALOG_NEED    = 9 + 2 * ANALOG_CHANNELS;
   localparam int DIGITAL_NEED   = 9 + 32;
   localparam int COUNTER_NEED   = 9 + 2 * COUNTER_CHANNELS;

   // frame bytes
   localparam logic [7:0] STX_CODE     = 8'h02;
   localparam logic [7:0] LEN_CODE     = 8'h07;
   localparam logic [7:0] READ_CODE    = 8'h4F;
   localparam logic [7:0] ANALOG_CODE  = 8'h2C;
   localparam logic [7:0] DIGITAL_CODE = 8'h0C;
   localparam logic [7:0] COUNTER_CODE = 8'h4C;
   localparam logic [7:0] ETX_CODE     = 8'h03;
   localparam logic [7:0] ON_CODE      = 8'hFF;

   // input commands
   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_BYTE  = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;

   // card types
   localparam logic [1:0] TYPE_ANALOG  = 2'd0;
   localparam logic [1:0] TYPE_DIGITAL = 2'd1;

   // result kinds
   localparam logic [1:0] KIND_TX     = 2'd0;
   localparam logic [1:0] KIND_WORD   = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;

   // final status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_BAD     = 2'd1;
   localparam logic [1:0] ST_TIMEOUT = 2'd2;

   // register indexes and reset values
   localparam logic REG_BUFFER_WORDS  = 1'b0;
   localparam logic REG_TIMEOUT_TICKS = 1'b1;
   localparam logic [15:0] BUFFER_WORDS_RESET  = 16'd4096;
   localparam logic [15:0] TIMEOUT_TICKS_RESET = 16'd1000;

   typedef struct packed {
      logic [15:0] buffer_words;
      logic [15:0] timeout_ticks;
   } icrt_cfg_type;

   // controller to datapath
   typedef struct packed {
      logic       start_load;
      logic       rx_store;
      logic       tick;
      logic       step_clr;
      logic       step_inc;
      logic       mem_rd;
      logic       rd_hi;
      logic       out_load;
      logic [1:0] out_kind;
      logic       out_dig;
      logic [1:0] out_status;
      logic       out_last;
   } icrt_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
      logic rx_full;
      logic timeout_hit;
      logic frame_good;
      logic type_digital;
      logic in_range;
      logic send_last;
      logic word_last;
   } icrt_stat_type;

endpackage

// ===== src/icrt_req_if.sv =====
// input channel of the i/o card read block: start, received byte and tick transactions
// no dependencies
interface icrt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [7:0]  station;
   logic [7:0]  card_address;
   logic [1:0]  card_type;
   logic [15:0] target_word;
   logic [7:0]  rx_byte;

   modport source (
      output valid, command, station, card_address, card_type, target_word, rx_byte,
      input  ready
   );
   modport sink (
      input  valid, command, station, card_address, card_type, target_word, rx_byte,
      output ready
   );
endinterface

// ===== src/icrt_rsp_if.sv =====
// result channel of the i/o card read block: transmit bytes, data words, final status
// no dependencies
interface icrt_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  tx_byte;
   logic [15:0] word_address;
   logic [15:0] word_value;
   logic [1:0]  status;
   logic        last;

   modport source (
      output valid, kind, tx_byte, word_address, word_value, status, last,
      input  ready
   );
   modport sink (
      input  valid, kind, tx_byte, word_address, word_value, status, last,
      output ready
   );
endinterface

// ===== src/icrt_csr.sv =====
// apb-style configuration registers: buffer size and timeout
// depends on icrt_pkg
module icrt_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [2:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready,
   output icrt_pkg::icrt_cfg_type cfg
);

   logic [15:0] buffer_words_ff, buffer_words_in;
   logic [15:0] timeout_ticks_ff, timeout_ticks_in;
   logic        wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      buffer_words_in  = buffer_words_ff;
      timeout_ticks_in = timeout_ticks_ff;
      if (wr_en) begin
         case (csr_paddr[2])
            icrt_pkg::REG_BUFFER_WORDS:  buffer_words_in  = csr_pwdata[15:0];
            icrt_pkg::REG_TIMEOUT_TICKS: timeout_ticks_in = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_words_ff  <= icrt_pkg::BUFFER_WORDS_RESET;
         timeout_ticks_ff <= icrt_pkg::TIMEOUT_TICKS_RESET;
      end else begin
         buffer_words_ff  <= buffer_words_in;
         timeout_ticks_ff <= timeout_ticks_in;
      end
   end

   always_comb begin
      case (csr_paddr[2])
         icrt_pkg::REG_TIMEOUT_TICKS: csr_prdata = {16'b0, timeout_ticks_ff};
         default:                     csr_prdata = {16'b0, buffer_words_ff};
      endcase
   end

   assign cfg.buffer_words  = buffer_words_ff;
   assign cfg.timeout_ticks = timeout_ticks_ff;

endmodule

// ===== src/icrt_dpath.sv =====
// datapath: request byte builder, reply store, running checks, word decode, result register
// depends on icrt_pkg; driven by icrt_ctrl through icrt_cmd_type
module icrt_dpath (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [7:0]              req_station,
   input  logic [7:0]              req_card_address,
   input  logic [1:0]              req_card_type,
   input  logic [15:0]             req_target_word,
   input  logic [7:0]              req_rx_byte,
   input  icrt_pkg::icrt_cfg_type  cfg,
   input  icrt_pkg::icrt_cmd_type  cmd,
   output icrt_pkg::icrt_stat_type stat,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic [1:0]              rsp_kind,
   output logic [7:0]              rsp_tx_byte,
   output logic [15:0]             rsp_word_address,
   output logic [15:0]             rsp_word_value,
   output logic [1:0]              rsp_status,
   output logic                    rsp_last
);

   localparam int CNT_W  = icrt_pkg::CNT_W;
   localparam int ADDR_W = icrt_pkg::ADDR_W;
   localparam int STEP_W = icrt_pkg::STEP_W;

   // transaction context latched at start
   logic [7:0]        station_ff, address_ff;
   logic [1:0]        type_ff;
   logic [15:0]       target_ff;
   logic [CNT_W-1:0]  needed_ff;

   // reply collection
   logic [7:0]        reply_store_ff [icrt_pkg::REPLY_DEPTH];
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [7:0]        sum_ff;
   logic              stx_ok_ff;
   logic              good_ff;
   logic [15:0]       dig_ff;
   logic [15:0]       elapsed_ff, elapsed_in;

   // sequencing and reads
   logic [STEP_W-1:0] step_ff;
   logic [7:0]        rd_data_ff, lo_ff;
   logic [ADDR_W-1:0] rd_addr;

   // result register
   logic              valid_ff, valid_in;
   logic [1:0]        kind_ff, status_ff;
   logic [7:0]        tx_ff;
   logic [15:0]       waddr_ff, wvalue_ff;
   logic              last_ff;

   logic [7:0]        type_code, req_sum, req_byte;
   logic              room, stx_now;
   logic [CNT_W-1:0]  cnt_off;
   logic [16:0]       analog_end, counter_end;
   logic [15:0]       word_addr, word_val;

   always_comb begin
      case (type_ff)
         icrt_pkg::TYPE_ANALOG:  type_code = icrt_pkg::ANALOG_CODE;
         icrt_pkg::TYPE_DIGITAL: type_code = icrt_pkg::DIGITAL_CODE;
         default:                type_code = icrt_pkg::COUNTER_CODE;
      endcase
   end

   assign req_sum = station_ff + address_ff + icrt_pkg::READ_CODE + type_code
                  + address_ff + icrt_pkg::ETX_CODE;

   always_comb begin
      case (step_ff)
         STEP_W'(0): req_byte = icrt_pkg::STX_CODE;
         STEP_W'(1): req_byte = icrt_pkg::LEN_CODE;
         STEP_W'(2): req_byte = station_ff;
         STEP_W'(3): req_byte = address_ff;
         STEP_W'(4): req_byte = icrt_pkg::READ_CODE;
         STEP_W'(5): req_byte = type_code;
         STEP_W'(6): req_byte = address_ff;
         STEP_W'(7): req_byte = icrt_pkg::ETX_CODE;
         default:    req_byte = req_sum;
      endcase
   end

   // byte arrival
   assign room     = count_ff < CNT_W'(icrt_pkg::REPLY_DEPTH);
   assign count_in = count_ff + CNT_W'(room);
   assign stx_now  = (count_ff == '0) ? (req_rx_byte == icrt_pkg::STX_CODE) : stx_ok_ff;
   assign cnt_off  = count_ff - CNT_W'(icrt_pkg::DATA_FIRST);

   always_ff @(posedge clock) begin
      if (cmd.rx_store && room) begin
         reply_store_ff[count_ff[ADDR_W-1:0]] <= req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.start_load) begin
         count_ff <= '0;
      end else if (cmd.rx_store) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_load) begin
         station_ff <= req_station;
         address_ff <= req_card_address;
         type_ff    <= req_card_type;
         target_ff  <= req_target_word;
         case (req_card_type)
            icrt_pkg::TYPE_ANALOG:  needed_ff <= CNT_W'(icrt_pkg::ANALOG_NEED);
            icrt_pkg::TYPE_DIGITAL: needed_ff <= CNT_W'(icrt_pkg::DIGITAL_NEED);
            default:                needed_ff <= CNT_W'(icrt_pkg::COUNTER_NEED);
         endcase
         sum_ff    <= '0;
         stx_ok_ff <= 1'b0;
         good_ff   <= 1'b0;
         dig_ff    <= '0;
      end else if (cmd.rx_store && room) begin
         stx_ok_ff <= stx_now;
         // the final byte is the sum byte; the last update wins
         good_ff   <= stx_now && (sum_ff == req_rx_byte);
         if (count_ff >= CNT_W'(icrt_pkg::SUM_FIRST) && count_in < needed_ff) begin
            sum_ff <= sum_ff + req_rx_byte;
         end
         // digital bits sit on the low byte of each pair
         if (count_ff >= CNT_W'(icrt_pkg::DATA_FIRST) && !cnt_off[0]
             && cnt_off < CNT_W'(2 * icrt_pkg::DIGITAL_BITS)) begin
            dig_ff[cnt_off[STEP_W:1]] <= (req_rx_byte == icrt_pkg::ON_CODE);
         end
      end
   end

   // tick counting, saturating
   assign elapsed_in = (elapsed_ff == 16'hFFFF) ? elapsed_ff : elapsed_ff + 16'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff <= '0;
      end else if (cmd.start_load) begin
         elapsed_ff <= '0;
      end else if (cmd.tick) begin
         elapsed_ff <= elapsed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else if (cmd.start_load || cmd.step_clr) begin
         step_ff <= '0;
      end else if (cmd.step_inc) begin
         step_ff <= step_ff + STEP_W'(1);
      end
   end

   // word reads: low byte then high byte of pair step
   assign rd_addr = ADDR_W'(icrt_pkg::DATA_FIRST) + ADDR_W'({step_ff, 1'b0})
                  + ADDR_W'(cmd.rd_hi);

   always_ff @(posedge clock) begin
      if (cmd.mem_rd) begin
         rd_data_ff <= reply_store_ff[rd_addr];
         if (cmd.rd_hi) begin
            lo_ff <= rd_data_ff;
         end
      end
   end

   assign analog_end  = {1'b0, target_ff} + 17'(icrt_pkg::ANALOG_CHANNELS);
   assign counter_end = {1'b0, target_ff} + 17'(icrt_pkg::COUNTER_CHANNELS);

   assign word_addr = cmd.out_dig ? target_ff : target_ff + 16'(step_ff);
   assign word_val  = cmd.out_dig ? dig_ff : {rd_data_ff, lo_ff};

   // result register
   assign stat.out_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (cmd.out_load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         kind_ff   <= cmd.out_kind;
         tx_ff     <= (cmd.out_kind == icrt_pkg::KIND_TX) ? req_byte : 8'd0;
         waddr_ff  <= (cmd.out_kind == icrt_pkg::KIND_WORD) ? word_addr : 16'd0;
         wvalue_ff <= (cmd.out_kind == icrt_pkg::KIND_WORD) ? word_val : 16'd0;
         status_ff <= (cmd.out_kind == icrt_pkg::KIND_STATUS) ? cmd.out_status
                                                               : icrt_pkg::ST_OK;
         last_ff   <= cmd.out_last;
      end
   end

   assign stat.rx_full      = count_in >= needed_ff;
   assign stat.timeout_hit  = elapsed_in >= cfg.timeout_ticks;
   assign stat.frame_good   = good_ff;
   assign stat.type_digital = type_ff == icrt_pkg::TYPE_DIGITAL;
   assign stat.in_range     = (type_ff == icrt_pkg::TYPE_ANALOG)
                            ? (analog_end < {1'b0, cfg.buffer_words})
                            : (counter_end < {1'b0, cfg.buffer_words});
   assign stat.send_last    = step_ff == STEP_W'(icrt_pkg::REQ_LAST);
   assign stat.word_last    = (type_ff == icrt_pkg::TYPE_ANALOG)
                            ? (step_ff == STEP_W'(icrt_pkg::ANALOG_CHANNELS - 1))
                            : (step_ff == STEP_W'(icrt_pkg::COUNTER_CHANNELS - 1));

   assign rsp_valid        = valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_tx_byte      = tx_ff;
   assign rsp_word_address = waddr_ff;
   assign rsp_word_value   = wvalue_ff;
   assign rsp_status       = status_ff;
   assign rsp_last         = last_ff;

endmodule

// ===== src/icrt_ctrl.sv =====
// controller state machine: request send, reply collection, frame check and word emission
// depends on icrt_pkg; steers icrt_dpath through icrt_cmd_type / icrt_stat_type
module icrt_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic [1:0]              req_command,
   output logic                    req_ready,
   input  icrt_pkg::icrt_stat_type stat,
   output icrt_pkg::icrt_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SEND   = 3'd1;
   localparam logic [2:0] S_CHECK  = 3'd2;
   localparam logic [2:0] S_RD_LO  = 3'd3;
   localparam logic [2:0] S_RD_HI  = 3'd4;
   localparam logic [2:0] S_WORD   = 3'd5;
   localparam logic [2:0] S_DIG    = 3'd6;
   localparam logic [2:0] S_STATUS = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       busy_ff, busy_in;
   logic       accept;

   // result register is free at acceptance, so a one-result transaction loads at once
   assign req_ready = (state_ff == S_IDLE) && stat.out_free;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      busy_in  = busy_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_command)
                  icrt_pkg::CMD_START: begin
                     if (!busy_ff) begin
                        cmd.start_load = 1'b1;
                        busy_in        = 1'b1;
                        state_in       = S_SEND;
                     end
                  end
                  icrt_pkg::CMD_BYTE: begin
                     if (busy_ff) begin
                        cmd.rx_store = 1'b1;
                        if (stat.rx_full) begin
                           busy_in  = 1'b0;
                           state_in = S_CHECK;
                        end
                     end
                  end
                  icrt_pkg::CMD_TICK: begin
                     if (busy_ff) begin
                        cmd.tick = 1'b1;
                        if (stat.timeout_hit) begin
                           busy_in        = 1'b0;
                           cmd.out_load   = 1'b1;
                           cmd.out_kind   = icrt_pkg::KIND_STATUS;
                           cmd.out_status = icrt_pkg::ST_TIMEOUT;
                           cmd.out_last   = 1'b1;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_SEND: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = icrt_pkg::KIND_TX;
               cmd.out_last = stat.send_last;
               cmd.step_inc = 1'b1;
               if (stat.send_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_CHECK: begin
            if (!stat.frame_good) begin
               if (stat.out_free) begin
                  cmd.out_load   = 1'b1;
                  cmd.out_kind   = icrt_pkg::KIND_STATUS;
                  cmd.out_status = icrt_pkg::ST_BAD;
                  cmd.out_last   = 1'b1;
                  state_in       = S_IDLE;
               end
            end else if (stat.type_digital) begin
               state_in = S_DIG;
            end else if (stat.in_range) begin
               cmd.step_clr = 1'b1;
               state_in     = S_RD_LO;
            end else begin
               state_in = S_STATUS;
            end
         end
         S_RD_LO: begin
            cmd.mem_rd = 1'b1;
            state_in   = S_RD_HI;
         end
         S_RD_HI: begin
            cmd.mem_rd = 1'b1;
            cmd.rd_hi  = 1'b1;
            state_in   = S_WORD;
         end
         S_WORD: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = icrt_pkg::KIND_WORD;
               if (stat.word_last) begin
                  state_in = S_STATUS;
               end else begin
                  cmd.step_inc = 1'b1;
                  state_in     = S_RD_LO;
               end
            end
         end
         S_DIG: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = icrt_pkg::KIND_WORD;
               cmd.out_dig  = 1'b1;
               state_in     = S_STATUS;
            end
         end
         S_STATUS: begin
            if (stat.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_kind   = icrt_pkg::KIND_STATUS;
               cmd.out_status = icrt_pkg::ST_OK;
               cmd.out_last   = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

`ifndef ASSERT_OFF
   a_send_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEND) |-> busy_ff)
      else $error("request send while not busy");

   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      (accept && req_command == icrt_pkg::CMD_BYTE && busy_ff && stat.rx_full)
      |=> (state_ff == S_CHECK && !busy_ff))
      else $error("completed frame did not enter check");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> stat.out_free)
      else $error("result loaded over a waiting transaction");

   a_read_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WORD && !$stable(state_ff)) |-> $past(state_ff) == S_RD_HI)
      else $error("word emitted without both byte reads");
`endif

endmodule

// ===== src/io_card_read_transaction.sv =====
// top level of the i/o card read transaction master: csr, controller and datapath
// depends on icrt_pkg, icrt_req_if, icrt_rsp_if, icrt_csr, icrt_ctrl, icrt_dpath
//
//  channel  direction  carries
//  req      in         start (station, address, type, target), rx byte, tick
//  rsp      out        transmit bytes, data words, final status with last
//  csr      in/out     apb writes/reads of buffer_words (0x0), timeout_ticks (0x4)
//
// byte and tick transactions complete on acceptance; a start is accepted, then the nine
// request bytes are loaded into the result register in turn.
// the frame-completing byte leads to a check state, then per data word the states rd_lo,
// rd_hi (two reads of the single-port reply store) and word, up to 16 words, then a status.
// reset is synchronous and clears control state; the reply store is not cleared.
// rsp_ready low holds the result register and the controller; req is taken only when idle.
module io_card_read_transaction (
   input  logic        clock,
   input  logic        reset,
   icrt_req_if.sink    req_port,
   icrt_rsp_if.source  rsp_port,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   icrt_pkg::icrt_cfg_type  cfg;
   icrt_pkg::icrt_cmd_type  cmd;
   icrt_pkg::icrt_stat_type stat;

   icrt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   icrt_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_port.valid),
      .req_command (req_port.command),
      .req_ready   (req_port.ready),
      .stat        (stat),
      .cmd         (cmd)
   );

   icrt_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_station      (req_port.station),
      .req_card_address (req_port.card_address),
      .req_card_type    (req_port.card_type),
      .req_target_word  (req_port.target_word),
      .req_rx_byte      (req_port.rx_byte),
      .cfg              (cfg),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_ready        (rsp_port.ready),
      .rsp_valid        (rsp_port.valid),
      .rsp_kind         (rsp_port.kind),
      .rsp_tx_byte      (rsp_port.tx_byte),
      .rsp_word_address (rsp_port.word_address),
      .rsp_word_value   (rsp_port.word_value),
      .rsp_status       (rsp_port.status),
      .rsp_last         (rsp_port.last)
   );

endmodule
